// File: hdl/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and constants for the first-fit slot allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

	localparam int OWN_W   = 16;
	localparam int RUN_W   = 7;
	localparam int CNT_W   = 7;
	localparam int START_W = 6;
	localparam int CMD_W   = 2;

	localparam logic [CMD_W-1:0] CMD_ALLOC    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE_ALL = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FREE_ONE = 2'd2;

	localparam logic [CNT_W-1:0] FREED_MAX      = 7'd127;
	localparam logic [CNT_W-1:0] ACTIVE_DEFAULT = 7'd64;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_MARK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic               success;
		logic [OWN_W-1:0]   owner;
		logic [START_W-1:0] start_slot;
		logic [CNT_W-1:0]   freed_count;
	} res_t;

endpackage

// File: hdl/first_fit_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_slot_allocator_core
// First-fit contiguous slot allocator with per-slot owner map.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears on the result ports for one cycle with done high and cannot be
// stalled. The map is scanned one slot per cycle through a slot memory with
// one read and one write port, and a successful allocation is then written
// back slot by slot; a request with an unknown command, zero length or an
// empty scan range skips the scan and goes straight to done. After reset the
// block runs a clearing pass over all SLOTS slots with busy high before it
// takes its first request; configuration writes are accepted at any time.
module first_fit_slot_allocator_core #(
	parameter int SLOTS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [ffsa_pkg::CMD_W-1:0]     cmd,
	input  logic [ffsa_pkg::RUN_W-1:0]     run_length,
	input  logic [ffsa_pkg::OWN_W-1:0]     owner_to_free,
	input  logic                           cfg_we,
	input  logic [ffsa_pkg::CNT_W-1:0]     cfg_wdata,
	output logic                           done,
	output logic                           success,
	output logic [ffsa_pkg::OWN_W-1:0]     owner,
	output logic [ffsa_pkg::START_W-1:0]   start_slot,
	output logic [ffsa_pkg::CNT_W-1:0]     freed_count
);

	localparam int AW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	logic [ffsa_pkg::CNT_W-1:0] active_slots_q;
	logic [ffsa_pkg::OWN_W-1:0] next_owner_q;
	ffsa_pkg::res_t             res;

	logic                       mem_we;
	logic [AW-1:0]              mem_waddr;
	logic [ffsa_pkg::OWN_W:0]   mem_wdata;
	logic [AW-1:0]              mem_raddr;
	logic [ffsa_pkg::OWN_W:0]   mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_slots_q <= ffsa_pkg::ACTIVE_DEFAULT;
		end else if (cfg_we) begin
			active_slots_q <= cfg_wdata;
		end
	end

	// every allocate request takes an owner number, even if it fails
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_owner_q <= '0;
		end else if (start && !busy && cmd == ffsa_pkg::CMD_ALLOC) begin
			next_owner_q <= next_owner_q + ffsa_pkg::OWN_W'(1);
		end
	end

	ffsa_seq #(
		.SLOTS (SLOTS),
		.AW    (AW),
		.CW    (CW)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.cmd           (cmd),
		.run_length    (run_length),
		.owner_to_free (owner_to_free),
		.next_owner    (next_owner_q),
		.active_slots  (active_slots_q),
		.busy          (busy),
		.done          (done),
		.res           (res),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata),
		.mem_raddr     (mem_raddr),
		.mem_rdata     (mem_rdata)
	);

	ffsa_map #(
		.DEPTH (SLOTS),
		.AW    (AW),
		.DW    (ffsa_pkg::OWN_W + 1)
	) u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign success     = res.success;
	assign owner       = res.owner;
	assign start_slot  = res.start_slot;
	assign freed_count = res.freed_count;

endmodule

// File: hdl/ffsa_map.sv
// ----------------------------------------------------------------------------
// ffsa_map
// Slot map storage: one busy bit and owner number per slot, one write and
// one registered read per cycle.
// ----------------------------------------------------------------------------
module ffsa_map #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 17
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/ffsa_seq.sv
// ----------------------------------------------------------------------------
// ffsa_seq
// Request sequencer: clearing pass, one-slot-per-cycle scan of the map that
// also releases freed slots, write-back of an allocated run, and result assembly.
// ----------------------------------------------------------------------------
module ffsa_seq #(
	parameter int SLOTS = 64,
	parameter int AW    = 6,
	parameter int CW    = 7
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ffsa_pkg::CMD_W-1:0]     cmd,
	input  logic [ffsa_pkg::RUN_W-1:0]     run_length,
	input  logic [ffsa_pkg::OWN_W-1:0]     owner_to_free,
	input  logic [ffsa_pkg::OWN_W-1:0]     next_owner,
	input  logic [ffsa_pkg::CNT_W-1:0]     active_slots,
	output logic                           busy,
	output logic                           done,
	output ffsa_pkg::res_t                 res,
	output logic                           mem_we,
	output logic [AW-1:0]                  mem_waddr,
	output logic [ffsa_pkg::OWN_W:0]       mem_wdata,
	output logic [AW-1:0]                  mem_raddr,
	input  logic [ffsa_pkg::OWN_W:0]       mem_rdata
);

	localparam int LW = (CW > ffsa_pkg::CNT_W) ? CW : ffsa_pkg::CNT_W;
	localparam int SW = ((AW > ffsa_pkg::RUN_W) ? AW : ffsa_pkg::RUN_W) + 1;
	localparam int XW = AW + ffsa_pkg::START_W;

	ffsa_pkg::state_t state_q, state_d;

	logic [ffsa_pkg::CMD_W-1:0] cmd_q;
	logic [ffsa_pkg::RUN_W-1:0] len_q;
	logic [ffsa_pkg::OWN_W-1:0] who_q;
	logic [ffsa_pkg::OWN_W-1:0] own_q;
	logic [CW-1:0]              lim_q;
	logic [CW-1:0]              rd_pos_q;
	logic [AW-1:0]              proc_pos_s1;
	logic                       proc_vld_s1;
	logic [ffsa_pkg::RUN_W-1:0] run_q;
	logic [ffsa_pkg::CNT_W-1:0] freed_q;
	logic                       found_q;
	logic [AW-1:0]              start_q;
	logic [AW-1:0]              mark_pos_q;
	logic [AW-1:0]              mark_end_q;
	logic [AW-1:0]              clr_pos_q;

	logic [LW-1:0]              act_w;
	logic [LW-1:0]              slots_w;
	logic [LW-1:0]              lim_full;
	logic [CW-1:0]              lim_w;
	logic                       accept;
	logic                       scan_on;
	logic                       issue;
	logic                       is_alloc;
	logic                       slot_busy;
	logic [ffsa_pkg::OWN_W-1:0] slot_owner;
	logic [ffsa_pkg::RUN_W-1:0] run_inc;
	logic                       hit_alloc;
	logic                       hit_free;
	logic [CW-1:0]              proc_next;
	logic                       scan_last;
	logic [SW-1:0]              run_start_w;
	logic [AW-1:0]              run_start;
	logic [XW-1:0]              start_ext;
	logic                       quick_done;

	// scan limit: active_slots clipped to the map size
	assign act_w    = LW'(active_slots);
	assign slots_w  = LW'(SLOTS);
	assign lim_full = (act_w > slots_w) ? slots_w : act_w;
	assign lim_w    = lim_full[CW-1:0];

	assign accept   = (state_q == ffsa_pkg::ST_IDLE) && start;
	assign scan_on  = (state_q == ffsa_pkg::ST_SCAN);
	assign issue    = scan_on && (rd_pos_q != lim_q);
	assign is_alloc = (cmd_q == ffsa_pkg::CMD_ALLOC);

	assign slot_busy  = mem_rdata[ffsa_pkg::OWN_W];
	assign slot_owner = mem_rdata[ffsa_pkg::OWN_W-1:0];
	assign run_inc    = run_q + ffsa_pkg::RUN_W'(1);

	assign hit_alloc = scan_on && proc_vld_s1 && is_alloc && !slot_busy && (run_inc == len_q);
	assign hit_free  = scan_on && proc_vld_s1 && !is_alloc && slot_busy &&
	                   (slot_owner == who_q);
	assign proc_next = CW'(proc_pos_s1) + CW'(1);
	assign scan_last = scan_on && proc_vld_s1 && (proc_next == lim_q);

	// run began len-1 slots before the current one
	assign run_start_w = SW'(proc_pos_s1) + SW'(1) - SW'(len_q);
	assign run_start   = run_start_w[AW-1:0];

	// unknown command, empty scan range or zero-length allocation finish at once
	assign quick_done = (cmd != ffsa_pkg::CMD_ALLOC && cmd != ffsa_pkg::CMD_FREE_ALL &&
	                     cmd != ffsa_pkg::CMD_FREE_ONE) ||
	                    (lim_w == '0) ||
	                    (cmd == ffsa_pkg::CMD_ALLOC && run_length == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ffsa_pkg::ST_CLEAR;
			clr_pos_q   <= '0;
			proc_vld_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			proc_vld_s1 <= issue;
			if (state_q == ffsa_pkg::ST_CLEAR) begin
				clr_pos_q <= clr_pos_q + AW'(1);
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = clr_pos_q;
		mem_wdata = '0;
		unique case (state_q)
			ffsa_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				if (clr_pos_q == AW'(SLOTS - 1)) begin
					state_d = ffsa_pkg::ST_IDLE;
				end
			end
			ffsa_pkg::ST_IDLE: begin
				if (start) begin
					state_d = quick_done ? ffsa_pkg::ST_DONE : ffsa_pkg::ST_SCAN;
				end
			end
			ffsa_pkg::ST_SCAN: begin
				if (hit_free) begin
					mem_we    = 1'b1;
					mem_waddr = proc_pos_s1;
					mem_wdata = {1'b0, slot_owner};
				end
				priority if (hit_alloc) begin
					state_d = ffsa_pkg::ST_MARK;
				end else if (hit_free && cmd_q == ffsa_pkg::CMD_FREE_ONE) begin
					state_d = ffsa_pkg::ST_DONE;
				end else if (scan_last) begin
					state_d = ffsa_pkg::ST_DONE;
				end
			end
			ffsa_pkg::ST_MARK: begin
				mem_we    = 1'b1;
				mem_waddr = mark_pos_q;
				mem_wdata = {1'b1, own_q};
				if (mark_pos_q == mark_end_q) begin
					state_d = ffsa_pkg::ST_DONE;
				end
			end
			ffsa_pkg::ST_DONE: begin
				state_d = ffsa_pkg::ST_IDLE;
			end
			default: begin
				state_d = ffsa_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd;
			len_q    <= run_length;
			who_q    <= owner_to_free;
			lim_q    <= lim_w;
			rd_pos_q <= '0;
			run_q    <= '0;
			freed_q  <= '0;
			found_q  <= 1'b0;
			if (cmd == ffsa_pkg::CMD_ALLOC) begin
				own_q <= next_owner;
			end else if (cmd == ffsa_pkg::CMD_FREE_ALL || cmd == ffsa_pkg::CMD_FREE_ONE) begin
				own_q <= owner_to_free;
			end else begin
				own_q <= '0;
			end
		end
		if (issue) begin
			rd_pos_q    <= rd_pos_q + CW'(1);
			proc_pos_s1 <= rd_pos_q[AW-1:0];
		end
		if (scan_on && proc_vld_s1) begin
			run_q <= slot_busy ? '0 : run_inc;
		end
		if (hit_alloc) begin
			found_q    <= 1'b1;
			start_q    <= run_start;
			mark_pos_q <= run_start;
			mark_end_q <= proc_pos_s1;
		end
		if (hit_free && freed_q != ffsa_pkg::FREED_MAX) begin
			freed_q <= freed_q + ffsa_pkg::CNT_W'(1);
		end
		if (state_q == ffsa_pkg::ST_MARK) begin
			mark_pos_q <= mark_pos_q + AW'(1);
		end
	end

	assign mem_raddr = rd_pos_q[AW-1:0];

	assign start_ext = XW'(start_q);

	assign busy = (state_q != ffsa_pkg::ST_IDLE);
	assign done = (state_q == ffsa_pkg::ST_DONE);

	assign res.success     = is_alloc ? found_q : (freed_q != '0);
	assign res.owner       = own_q;
	assign res.start_slot  = found_q ? start_ext[ffsa_pkg::START_W-1:0] : '0;
	assign res.freed_count = freed_q;

endmodule

// File: test/tb_first_fit_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// tb_first_fit_slot_allocator_core
// Self-checking bench for the first-fit slot allocator. A local copy of the
// slot map predicts every response: directed runs cover empty and full maps,
// reuse of freed slots, stale owners, unknown commands and the active slot
// count at its limits. Random traffic then mixes allocations and frees under
// several slot counts.
// ----------------------------------------------------------------------------
module tb_first_fit_slot_allocator_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 64;
	localparam logic [ffsa_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;

	logic                           clk;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	logic [ffsa_pkg::CMD_W-1:0]     cmd;
	logic [ffsa_pkg::RUN_W-1:0]     run_length;
	logic [ffsa_pkg::OWN_W-1:0]     owner_to_free;
	logic                           cfg_we;
	logic [ffsa_pkg::CNT_W-1:0]     cfg_wdata;
	logic                           done;
	logic                           success;
	logic [ffsa_pkg::OWN_W-1:0]     owner;
	logic [ffsa_pkg::START_W-1:0]   start_slot;
	logic [ffsa_pkg::CNT_W-1:0]     freed_count;

	// local copy of the slot map
	logic                           map_busy [SLOTS];
	logic [ffsa_pkg::OWN_W-1:0]     map_owner [SLOTS];
	logic [ffsa_pkg::OWN_W-1:0]     owner_counter;
	logic [ffsa_pkg::CNT_W-1:0]     active_slots;
	logic [ffsa_pkg::OWN_W-1:0]     live_owners[$];

	ffsa_pkg::res_t                 pending_outcomes[$];
	int                             mismatch_count;
	bit                             no_gaps;

	first_fit_slot_allocator_core #(
		.SLOTS(SLOTS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.run_length   (run_length),
		.owner_to_free(owner_to_free),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.done         (done),
		.success      (success),
		.owner        (owner),
		.start_slot   (start_slot),
		.freed_count  (freed_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Applies one request to the local map and returns the response it gives.
	function automatic ffsa_pkg::res_t compute_outcome(
			input logic [ffsa_pkg::CMD_W-1:0] c,
			input logic [ffsa_pkg::RUN_W-1:0] len,
			input logic [ffsa_pkg::OWN_W-1:0] who);
		ffsa_pkg::res_t r;
		int   lim;
		int   run;
		int   freed;
		int   first;
		int   i;
		r = '0;
		lim = (int'(active_slots) > SLOTS) ? SLOTS : int'(active_slots);
		run = 0;
		freed = 0;
		case (c)
		ffsa_pkg::CMD_ALLOC: begin
			r.owner = owner_counter;
			owner_counter = owner_counter + ffsa_pkg::OWN_W'(1);
			if (len != '0) begin
				for (int p = 0; p < lim; p++) begin
					if (map_busy[p]) begin
						run = 0;
					end else begin
						run++;
						if (run == int'(len)) begin
							first = p + 1 - int'(len);
							for (int k = first; k <= p; k++) begin
								map_busy[k] = 1'b1;
								map_owner[k] = r.owner;
							end
							r.success = 1'b1;
							r.start_slot = ffsa_pkg::START_W'(first);
							live_owners.push_back(r.owner);
							break;
						end
					end
				end
			end
		end
		ffsa_pkg::CMD_FREE_ALL, ffsa_pkg::CMD_FREE_ONE: begin
			r.owner = who;
			// owner of a free slot is never looked at
			for (int p = 0; p < lim; p++) begin
				if (map_busy[p] && map_owner[p] == who) begin
					map_busy[p] = 1'b0;
					freed++;
					if (c == ffsa_pkg::CMD_FREE_ONE)
						break;
				end
			end
			if (freed > int'(ffsa_pkg::FREED_MAX))
				freed = int'(ffsa_pkg::FREED_MAX);
			r.freed_count = ffsa_pkg::CNT_W'(freed);
			r.success = (freed != 0);
			if (c == ffsa_pkg::CMD_FREE_ALL) begin
				for (i = live_owners.size() - 1; i >= 0; i--)
					if (live_owners[i] == who)
						live_owners.delete(i);
			end
		end
		default: begin
		end
		endcase
		return r;
	endfunction

	task automatic issue_request(input logic [ffsa_pkg::CMD_W-1:0] c,
			input logic [ffsa_pkg::RUN_W-1:0] len,
			input logic [ffsa_pkg::OWN_W-1:0] who);
		int gap;
		gap = no_gaps ? 0 : int'($urandom_range(0, 11));
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		run_length <= len;
		owner_to_free <= who;
		do @(posedge clk); while (busy !== 1'b0);
		pending_outcomes.push_back(compute_outcome(c, len, who));
	endtask

	// Stop sending and hold off until every response is in.
	task automatic drain_outcomes();
		start <= 1'b0;
		while (pending_outcomes.size() != 0 || busy !== 1'b0) @(posedge clk);
	endtask

	// Caller drains first, so the block is idle here.
	task automatic write_active_slots(input logic [ffsa_pkg::CNT_W-1:0] value);
		while (busy !== 1'b0) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		active_slots = value;
		@(posedge clk);
	endtask

	task automatic issue_random_request();
		int                           pick;
		logic [ffsa_pkg::RUN_W-1:0]   len;
		logic [ffsa_pkg::OWN_W-1:0]   who;
		pick = $urandom_range(0, 99);
		len = ffsa_pkg::RUN_W'($urandom);
		who = ffsa_pkg::OWN_W'($urandom);
		if (live_owners.size() != 0 && $urandom_range(0, 3) != 0)
			who = live_owners[$urandom_range(0, live_owners.size() - 1)];
		if (pick < 50) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				len = ffsa_pkg::RUN_W'($urandom_range(1, 8));
			else if (pick < 90)
				len = ffsa_pkg::RUN_W'($urandom_range(9, 64));
			else if (pick < 95)
				len = '0;
			else
				len = ffsa_pkg::RUN_W'($urandom_range(65, 127));
			issue_request(ffsa_pkg::CMD_ALLOC, len, who);
		end else if (pick < 75) begin
			issue_request(ffsa_pkg::CMD_FREE_ALL, len, who);
		end else if (pick < 95) begin
			issue_request(ffsa_pkg::CMD_FREE_ONE, len, who);
		end else begin
			issue_request(CMD_UNKNOWN, len, who);
		end
	endtask

	task automatic test_alloc_and_free();
		logic [ffsa_pkg::OWN_W-1:0] single;
		logic [ffsa_pkg::OWN_W-1:0] big;
		logic [ffsa_pkg::OWN_W-1:0] page;
		issue_request(ffsa_pkg::CMD_ALLOC, 7'd0, '0);
		single = owner_counter;
		issue_request(ffsa_pkg::CMD_ALLOC, 7'd1, '0);
		issue_request(ffsa_pkg::CMD_ALLOC, 7'd64, '0);
		big = owner_counter;
		issue_request(ffsa_pkg::CMD_ALLOC, 7'd63, '0);
		issue_request(ffsa_pkg::CMD_ALLOC, 7'd1, '0);
		issue_request(ffsa_pkg::CMD_FREE_ONE, 7'd0, big);
		page = owner_counter;
		issue_request(ffsa_pkg::CMD_ALLOC, 7'd1, '0);
		issue_request(ffsa_pkg::CMD_FREE_ALL, 7'd0, big);
		issue_request(ffsa_pkg::CMD_FREE_ALL, 7'd0, single);
		issue_request(ffsa_pkg::CMD_FREE_ONE, 7'd0, page);
		issue_request(ffsa_pkg::CMD_FREE_ONE, 7'd0, page);
		big = owner_counter;
		issue_request(ffsa_pkg::CMD_ALLOC, 7'd64, '0);
		issue_request(ffsa_pkg::CMD_ALLOC, 7'd127, '0);
		issue_request(CMD_UNKNOWN, 7'd127, 16'hFFFF);
		issue_request(ffsa_pkg::CMD_FREE_ALL, 7'd0, 16'hFFFF);
		issue_request(ffsa_pkg::CMD_FREE_ALL, 7'd0, big);
		// freed slots still carry the old owner
		issue_request(ffsa_pkg::CMD_FREE_ALL, 7'd0, big);
		drain_outcomes();
	endtask

	task automatic test_active_count();
		logic [ffsa_pkg::OWN_W-1:0] first;
		logic [ffsa_pkg::OWN_W-1:0] rest;
		write_active_slots(7'd1);
		first = owner_counter;
		issue_request(ffsa_pkg::CMD_ALLOC, 7'd1, '0);
		issue_request(ffsa_pkg::CMD_ALLOC, 7'd2, '0);
		drain_outcomes();
		write_active_slots(7'd0);
		issue_request(ffsa_pkg::CMD_ALLOC, 7'd1, '0);
		issue_request(ffsa_pkg::CMD_FREE_ALL, 7'd0, first);
		drain_outcomes();
		write_active_slots(7'd127);
		rest = owner_counter;
		issue_request(ffsa_pkg::CMD_ALLOC, 7'd63, '0);
		issue_request(ffsa_pkg::CMD_FREE_ALL, 7'd0, first);
		drain_outcomes();
		// slots past the count keep their owner
		write_active_slots(7'd8);
		issue_request(ffsa_pkg::CMD_FREE_ALL, 7'd0, rest);
		drain_outcomes();
		write_active_slots(ffsa_pkg::ACTIVE_DEFAULT);
		issue_request(ffsa_pkg::CMD_FREE_ALL, 7'd0, rest);
		drain_outcomes();
	endtask

	task automatic test_random_traffic();
		logic [ffsa_pkg::CNT_W-1:0] counts [8];
		counts = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd0, 7'd0, 7'd64, 7'd0};
		counts[4] = ffsa_pkg::CNT_W'($urandom_range(2, 63));
		counts[5] = ffsa_pkg::CNT_W'($urandom_range(2, 63));
		counts[7] = ffsa_pkg::CNT_W'($urandom_range(1, 64));
		for (int ph = 0; ph < 8; ph++) begin
			write_active_slots(counts[ph]);
			no_gaps = (ph % 3 == 2);
			for (int n = 0; n < 64; n++) begin
				issue_random_request();
				if (n == 31)
					drain_outcomes();
			end
			drain_outcomes();
		end
		no_gaps = 1'b0;
	endtask

	task automatic compare_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch: expected %0d, got %0d", $time, what, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin : check_results
		ffsa_pkg::res_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_outcomes.size() == 0) begin
				$display({"%0t ns: response with no request outstanding: ",
					"expected none, got %0d %0d %0d %0d"},
					$time, success, owner, start_slot, freed_count);
				mismatch_count++;
			end else begin
				want = pending_outcomes.pop_front();
				compare_field("success", 32'(want.success), 32'(success));
				compare_field("owner", 32'(want.owner), 32'(owner));
				compare_field("start_slot", 32'(want.start_slot), 32'(start_slot));
				compare_field("freed_count", 32'(want.freed_count), 32'(freed_count));
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= ffsa_pkg::CMD_ALLOC;
		run_length <= '0;
		owner_to_free <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		mismatch_count = 0;
		no_gaps = 1'b0;
		for (int p = 0; p < SLOTS; p++)
			map_busy[p] = 1'b0;
		owner_counter = '0;
		active_slots = ffsa_pkg::ACTIVE_DEFAULT;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_alloc_and_free();
		test_active_count();
		test_random_traffic();

		drain_outcomes();
		repeat (2 * SLOTS) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: first_fit_slot_allocator_core.f
hdl/ffsa_pkg.sv
hdl/ffsa_map.sv
hdl/ffsa_seq.sv
hdl/first_fit_slot_allocator_core.sv
test/tb_first_fit_slot_allocator_core.sv
